>>> rtl/core/cwl_pkg.sv
// ----------------------------------------------------------------------------
// cwl_pkg: shared types and codes for the card ID whitelist table
// Holds the channel words, the scan token, the table update command and the
// operation and status codes.
// ----------------------------------------------------------------------------
package cwl_pkg;

    // Slot numbers are 1-based and reach the largest supported table depth.
    localparam int SLOT_W = 8;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_ERASE  = 2'd3;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_PRESENT     = 2'd1;
    localparam logic [1:0] ST_FULL        = 2'd2;
    localparam logic [1:0] ST_NOT_PRESENT = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] card_id;
    } t_in_word;

    typedef struct packed {
        logic       found;
        logic [6:0] slot;
        logic       is_master;
        logic [1:0] status;
        logic [6:0] entries_now;
    } t_out_word;

    // Search token handed from cell to cell, one cell per cycle.
    typedef struct packed {
        logic              valid;
        logic              live;   // probe may match at all
        logic              found;
        logic [SLOT_W-1:0] slot;
    } t_tok;

    // Table update, applied to every cell in one cycle.
    typedef struct packed {
        logic              add_en;
        logic              del_en;
        logic              clr_en;
        logic [SLOT_W-1:0] del_idx;  // 0-based index of the removed entry
    } t_upd;

endpackage

>>> rtl/core/card_id_whitelist_table.sv
// ----------------------------------------------------------------------------
// card_id_whitelist_table: packed table of card IDs with lookup and edit
// Input words carry an operation and a card ID; one output word comes back
// for each, with hit, slot, master flag, status and the new entry count.
// The user must write the master ID register through i_cfg_wr_en /
// i_cfg_wr_data only while the block is idle; the block does not enforce it.
// A word is taken when i_in_valid is high and o_in_stall is low, and a
// result leaves when o_out_valid is high and i_out_stall is low.
// The probe is registered on accept, then the search token walks the row
// of cells one cell per cycle, so one word is in flight at a time and a new
// word is taken only after the last search has finished and been decided.
// The next word is taken while the last result still waits in the output
// register; if the receiver stalls, the finished search holds in place and
// the table is not changed until the result register frees up.
// Reset empties the table and clears the master ID to zero; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module card_id_whitelist_table
    import cwl_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        r_state;
    logic [31:0]       r_master_id;
    logic [31:0]       r_probe;
    logic [1:0]        r_op;
    logic              r_master;
    logic              r_start;
    logic              r_found;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    t_out_word         r_out;
    logic [1:0]        n_status;
    t_upd              n_upd;
    t_upd              upd;
    logic              in_take;
    logic              finish;
    t_tok              start_tok;

    t_tok              tok   [MAX_ENTRIES+1];
    logic              used  [MAX_ENTRIES+2];
    logic [31:0]       ids   [MAX_ENTRIES+1];

    assign in_take = i_in_valid && (r_state == S_IDLE);
    assign finish  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        start_tok.valid = r_start;
        start_tok.live  = (r_probe[31:24] != 8'd0);
        start_tok.found = 1'b0;
        start_tok.slot  = '0;
    end

    assign tok[0]               = start_tok;
    assign used[0]              = 1'b1;
    assign used[MAX_ENTRIES+1]  = 1'b0;
    assign ids[MAX_ENTRIES]     = '0;

    generate
        for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            cwl_cell #(
                .IDX(g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_probe     (r_probe),
                .i_tok       (tok[g]),
                .o_tok       (tok[g+1]),
                .i_upd       (upd),
                .i_prev_used (used[g]),
                .i_next_used (used[g+2]),
                .i_next_id   (ids[g+1]),
                .o_used      (used[g+1]),
                .o_id        (ids[g])
            );
        end
    endgenerate

    // Decide the result and the table edit from the finished search.
    always_comb begin
        n_count       = r_count;
        n_status      = ST_OK;
        n_upd         = '0;
        n_upd.del_idx = r_slot - SLOT_W'(1);
        unique case (r_op)
            OP_LOOKUP: begin
                n_status = r_found ? ST_OK : ST_NOT_PRESENT;
            end
            OP_ADD: begin
                if (r_found) begin
                    n_status = ST_PRESENT;
                end else if (r_count >= CNT_MAX) begin
                    n_status = ST_FULL;
                end else begin
                    n_upd.add_en = 1'b1;
                    n_count      = r_count + CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (!r_found) begin
                    n_status = ST_NOT_PRESENT;
                end else begin
                    n_upd.del_en = 1'b1;
                    n_count      = r_count - CNT_W'(1);
                end
            end
            OP_ERASE: begin
                n_upd.clr_en = 1'b1;
                n_count      = '0;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        upd = '0;
        if (finish) begin
            upd = n_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_id <= '0;
        end else if (i_cfg_wr_en) begin
            r_master_id <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= in_take;
            // load a new result, else drop the one the receiver took
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (tok[MAX_ENTRIES].valid) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (finish) begin
                        r_count <= n_count;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_probe  <= i_in_word.card_id;
            r_op     <= i_in_word.operation;
            r_master <= (i_in_word.card_id[31:24] != 8'd0)
                        && (i_in_word.card_id == r_master_id);
        end
        if ((r_state == S_SCAN) && tok[MAX_ENTRIES].valid) begin
            r_found <= tok[MAX_ENTRIES].found;
            r_slot  <= tok[MAX_ENTRIES].slot;
        end
        if (finish) begin
            r_out.found       <= r_found;
            r_out.slot        <= r_slot[6:0];
            r_out.is_master   <= r_master;
            r_out.status      <= n_status;
            r_out.entries_now <= 7'(n_count);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

>>> rtl/core/cwl_cell.sv
// ----------------------------------------------------------------------------
// cwl_cell: one entry of the whitelist table
// Stores one card ID and its in-use bit, checks the passing search token
// against the probe, and takes part in append, shift-down and clear.
// ----------------------------------------------------------------------------
module cwl_cell
    import cwl_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_probe,
    input  t_tok        i_tok,
    output t_tok        o_tok,
    input  t_upd        i_upd,
    input  logic        i_prev_used,
    input  logic        i_next_used,
    input  logic [31:0] i_next_id,
    output logic        o_used,
    output logic [31:0] o_id
);

    localparam logic [SLOT_W-1:0] MY_IDX  = SLOT_W'(IDX);
    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX + 1);

    logic [31:0] r_id;
    logic        r_used;
    t_tok        r_tok;
    t_tok        n_tok;
    logic        hit;

    assign hit = r_used && (r_id == i_probe);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && i_tok.live && !i_tok.found && hit) begin
            n_tok.found = 1'b1;
            n_tok.slot  = MY_SLOT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.live  <= n_tok.live;
        r_tok.found <= n_tok.found;
        r_tok.slot  <= n_tok.slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_upd.clr_en) begin
            r_used <= 1'b0;
        end else if (i_upd.del_en && (MY_IDX >= i_upd.del_idx)) begin
            // shift down: take the neighbor's entry
            r_used <= i_next_used;
        end else if (i_upd.add_en && !r_used && i_prev_used) begin
            r_used <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.del_en && (MY_IDX >= i_upd.del_idx)) begin
            r_id <= i_next_id;
        end else if (i_upd.add_en && !r_used && i_prev_used) begin
            r_id <= i_probe;
        end
    end

    assign o_tok  = r_tok;
    assign o_used = r_used;
    assign o_id   = r_id;

endmodule
